### rtl/qtts_pkg.sv
// ----------------------------------------------------------------------------
// qtts_pkg
// Shared types, constants and character classes of the query token splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package qtts_pkg;

    localparam int MAX_TOKEN_INDEX = 255;
    localparam int TOK_W           = $clog2(MAX_TOKEN_INDEX + 1);
    localparam logic [TOK_W-1:0] TOK_MAX = TOK_W'(MAX_TOKEN_INDEX);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [Q_CNT_W-1:0] Q_ACCEPT_MAX = Q_CNT_W'(Q_DEPTH - 2);

    localparam logic [7:0] QUOTE_CHAR = 8'd39;
    localparam logic [7:0] LOWER_LO   = 8'd96;
    localparam logic [7:0] LOWER_HI   = 8'd123;
    localparam logic [7:0] CASE_DIFF  = 8'd32;

    typedef struct packed {
        logic [7:0] out_char;
        logic       kept;
        logic [7:0] token_index;
        logic       is_last;
    } t_result;

    typedef struct packed {
        logic    [1:0] count;
        t_result       first;
        t_result       second;
    } t_push;

    typedef struct packed {
        logic             inside_string;
        logic             quote_pending;
        logic             at_line_start;
        logic [TOK_W-1:0] token_counter;
    } t_core_status;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd13);
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        logic hit;
        unique case (c)
            "(", ")", "*", "+", "-", "/", ",", ";",
            "<", ">", "=", "|", "%", "&", "@", "!": hit = 1'b1;
            default:                                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [7:0] to_index(input logic [TOK_W-1:0] cnt);
        logic [TOK_W+7:0] ext;
        ext = {8'd0, cnt};
        return ext[7:0];
    endfunction

endpackage

`default_nettype wire

### rtl/qtts_if.sv
// ----------------------------------------------------------------------------
// qtts_in_if / qtts_out_if
// Valid/ready channels for raw line bytes and tagged token characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_line;

    modport source (output valid, output text_char, output end_of_line, input ready);
    modport sink   (input valid, input text_char, input end_of_line, output ready);
endinterface

interface qtts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       kept;
    logic [7:0] token_index;
    logic       is_last;

    modport source (output valid, output out_char, output kept, output token_index,
                    output is_last, input ready);
    modport sink   (input valid, input out_char, input kept, input token_index,
                    input is_last, output ready);
endinterface

`default_nettype wire

### rtl/qtts_core.sv
// ----------------------------------------------------------------------------
// qtts_core
// Per-byte split decision: string tracking, quote lookahead, token counting.
// ----------------------------------------------------------------------------
`default_nettype none

module qtts_core
    import qtts_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_fire,
    input  wire logic [7:0]   i_text_char,
    input  wire logic         i_end_of_line,
    output t_push             o_push,
    output t_core_status      o_status
);

    logic             r_inside, n_inside;
    logic             r_pending, n_pending;
    logic [7:0]       r_prev, n_prev;
    logic             r_line_start, n_line_start;
    logic [TOK_W-1:0] r_cnt, n_cnt;

    logic             is_q;
    logic             handled;
    logic             fresh;
    logic             a_v;
    logic             b_v;
    logic             m_v;
    logic [7:0]       b_char;
    logic [TOK_W-1:0] cnt_b;
    t_result          res_a;
    t_result          res_b;
    t_result          res_m;
    t_push            push;

    always_comb begin
        n_inside     = r_inside;
        n_pending    = r_pending;
        n_prev       = r_prev;
        n_line_start = r_line_start;
        cnt_b        = r_cnt;
        handled      = 1'b0;
        fresh        = 1'b0;
        a_v          = 1'b0;
        b_v          = 1'b0;
        b_char       = i_text_char;
        is_q         = (i_text_char == QUOTE_CHAR);

        // held quote: doubled quote or end of string
        if (r_pending) begin
            n_pending = 1'b0;
            a_v       = 1'b1;
            if (is_q) begin
                n_prev       = QUOTE_CHAR;
                n_line_start = 1'b0;
                handled      = 1'b1;
            end else begin
                n_inside = 1'b0;
            end
        end

        if (!handled) begin
            if (is_q) begin
                if (n_inside) begin
                    if (i_end_of_line) begin
                        n_inside = 1'b0;
                    end else begin
                        n_pending    = 1'b1;
                        n_prev       = i_text_char;
                        n_line_start = 1'b0;
                        handled      = 1'b1;
                    end
                end else begin
                    n_inside = 1'b1;
                    fresh    = 1'b1;
                end
            end else if (!n_inside) begin
                if (is_space(i_text_char) || is_special(i_text_char)) begin
                    fresh = !r_line_start && !is_space(r_prev);
                end else begin
                    fresh = !r_line_start && is_special(r_prev);
                end
                if (!r_line_start && (i_text_char == ">" || i_text_char == "=")
                        && (r_prev == "<" || r_prev == ">")) begin
                    fresh = 1'b0;
                end
                if (!r_line_start && i_text_char == "|" && r_prev == "|") begin
                    fresh = 1'b0;
                end
            end
        end

        if (!handled) begin
            if (fresh && !(is_q && (r_line_start || is_space(r_prev)))
                    && (r_cnt < TOK_MAX)) begin
                cnt_b = r_cnt + 1'b1;
            end
            b_v = !is_space(i_text_char) || n_inside;
            if (!n_inside && (i_text_char > LOWER_LO) && (i_text_char < LOWER_HI)) begin
                b_char = i_text_char - CASE_DIFF;
            end
            n_prev       = i_text_char;
            n_line_start = 1'b0;
        end

        n_cnt = cnt_b;
        m_v   = i_end_of_line && !a_v && !b_v;

        if (i_end_of_line) begin
            n_inside     = 1'b0;
            n_pending    = 1'b0;
            n_prev       = 8'd0;
            n_line_start = 1'b1;
            n_cnt        = '0;
        end
    end

    always_comb begin
        res_a = '{out_char: QUOTE_CHAR, kept: 1'b1, token_index: to_index(r_cnt),
                  is_last: 1'b0};
        res_b = '{out_char: b_char, kept: 1'b1, token_index: to_index(cnt_b),
                  is_last: 1'b0};
        res_m = '{out_char: 8'd0, kept: 1'b0, token_index: to_index(cnt_b),
                  is_last: 1'b0};

        push.second = res_b;
        if (a_v) begin
            push.first = res_a;
        end else if (b_v) begin
            push.first = res_b;
        end else begin
            push.first = res_m;
        end

        push.count = {1'b0, a_v} + {1'b0, b_v} + {1'b0, m_v};
        if (!i_fire) begin
            push.count = 2'd0;
        end

        if (a_v && b_v) begin
            push.second.is_last = i_end_of_line;
        end else begin
            push.first.is_last = i_end_of_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b0;
            r_pending    <= 1'b0;
            r_prev       <= 8'd0;
            r_line_start <= 1'b1;
            r_cnt        <= '0;
        end else if (i_fire) begin
            r_inside     <= n_inside;
            r_pending    <= n_pending;
            r_prev       <= n_prev;
            r_line_start <= n_line_start;
            r_cnt        <= n_cnt;
        end
    end

    assign o_push   = push;
    assign o_status = '{inside_string: r_inside, quote_pending: r_pending,
                        at_line_start: r_line_start, token_counter: r_cnt};

endmodule

`default_nettype wire

### rtl/qtts_outq.sv
// ----------------------------------------------------------------------------
// qtts_outq
// Result register bank: takes up to two results a cycle, hands out one when the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module qtts_outq
    import qtts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_push                   i_push,
    output logic [Q_CNT_W-1:0]      o_count,
    qtts_out_if.source              o_result
);

    t_result              r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, n_wr;
    logic [Q_PTR_W-1:0]   r_rd, n_rd;
    logic [Q_CNT_W-1:0]   r_count, n_count;
    logic [Q_PTR_W-1:0]   wr_next;
    logic                 pop;
    t_result              head;

    assign wr_next = r_wr + 1'b1;
    assign pop     = o_result.valid && o_result.ready;
    assign head    = r_slot[r_rd];

    always_comb begin
        n_wr    = r_wr + Q_PTR_W'(i_push.count);
        n_rd    = r_rd + Q_PTR_W'(pop);
        n_count = r_count + Q_CNT_W'(i_push.count) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_slot[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_slot[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_count              = r_count;
    assign o_result.valid       = (r_count != '0);
    assign o_result.out_char    = head.out_char;
    assign o_result.kept        = head.kept;
    assign o_result.token_index = head.token_index;
    assign o_result.is_last     = head.is_last;

endmodule

`default_nettype wire

### rtl/query_text_token_splitter.sv
// ----------------------------------------------------------------------------
// query_text_token_splitter
// Splits a query line into tokens, one byte in per cycle while the queue has room, tagged bytes out.
//
//   channel    dir   payload                                   per word
//   i_text     in    text_char, end_of_line                    one line byte
//   o_result   out   out_char, kept, token_index, is_last      one result
//
// a byte is accepted every cycle while at most two results are queued
// a byte yields zero, one or two results, the first from a held quote
// results leave one per cycle; an output stall backs up into i_text.ready
// synchronous active-low reset empties the queue and starts a new line
// ----------------------------------------------------------------------------
`default_nettype none

module query_text_token_splitter
    import qtts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    qtts_in_if.sink      i_text,
    qtts_out_if.source   o_result
);

    logic                 fire;
    logic [Q_CNT_W-1:0]   q_count;
    t_push                push;
    t_core_status         status;

    assign i_text.ready = (q_count <= Q_ACCEPT_MAX);
    assign fire         = i_text.valid && i_text.ready;

    qtts_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_text_char   (i_text.text_char),
        .i_end_of_line (i_text.end_of_line),
        .o_push        (push),
        .o_status      (status)
    );

    qtts_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_count  (q_count),
        .o_result (o_result)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_text.end_of_line |=> status.at_line_start && !status.quote_pending
            && !status.inside_string && (status.token_counter == '0))
        else $error("state not cleared after end of line");

    a_count_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !i_text.end_of_line |=> status.token_counter >= $past(status.token_counter))
        else $error("token counter went down within a line");

    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |-> push.count == 2'd0)
        else $error("results pushed without an accepted byte");

endmodule

`default_nettype wire
